// ----- hw/rtl/hsss_pkg.sv -----
// package: constants, types and the half-step coil table of the stepper sequencer
`timescale 1ns / 1ps
`default_nettype none

package hsss_pkg;

   localparam int TIMER_WIDTH = 24;

   localparam int SPR_WIDTH     = 15;
   localparam int PERIOD_WIDTH  = 24;
   localparam int STEPS_WIDTH   = 16;
   localparam int COIL_WIDTH    = 4;
   localparam int PHASE_WIDTH   = 3;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 40;

   localparam logic [SPR_WIDTH-1:0]    SPR_RESET    = 15'd4096;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 24'd977;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_STEPS_PER_REV = 1'b0,
      REG_STEP_PERIOD   = 1'b1
   } reg_index_type;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_MOVE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                   stepped;
      logic                   busy_res;
      logic [STEPS_WIDTH-1:0] steps_remaining;
      logic [SPR_WIDTH-1:0]   position;
      logic [COIL_WIDTH-1:0]  coils;
   } rsp_type;

   function automatic logic [COIL_WIDTH-1:0] half_step_coils(input logic [PHASE_WIDTH-1:0] phase);
      logic [COIL_WIDTH-1:0] pattern;
      unique case (phase)
         3'd0: pattern = 4'h1;
         3'd1: pattern = 4'h3;
         3'd2: pattern = 4'h2;
         3'd3: pattern = 4'h6;
         3'd4: pattern = 4'h4;
         3'd5: pattern = 4'hC;
         3'd6: pattern = 4'h8;
         3'd7: pattern = 4'h9;
         default: pattern = '0;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/half_step_stepper_sequencer.sv -----
// top level: half-step sequencer for a four-coil stepper, stream in and out, apb registers
//
//  channel  | direction | beat contents
//  req_     | in        | tdata: move_steps; tuser: req_type (0 tick, 1 move)
//  rsp_     | out       | tdata: coils, position, steps_remaining, busy_res, stepped
//  csr_     | in/out    | apb: steps_per_rev at 0x0, step_period at 0x4
//
// one beat accepted per cycle unless rsp_ stalls; a request beat passes through the
// input register, then the state update and result register
// reset is synchronous; registers return to 4096 / 977, motor idle, timer saturated
// a stall on rsp_ holds the result register and the input register, then req_tready falls
`timescale 1ns / 1ps
`default_nettype none

module half_step_stepper_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // move_steps[15:0]
   input  wire logic [hsss_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // req_type[0]
   input  wire logic                                req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // coils[3:0], position[18:4], steps_remaining[34:19], busy_res[35], stepped[36], zero[39:37]
   output logic [hsss_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [hsss_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [hsss_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [hsss_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   localparam int TW = hsss_pkg::TIMER_WIDTH;
   localparam int SW = hsss_pkg::SPR_WIDTH;
   localparam int NW = hsss_pkg::STEPS_WIDTH;

   // configuration registers
   logic [SW-1:0]                       spr_ff, spr_in;
   logic [hsss_pkg::PERIOD_WIDTH-1:0]   period_ff, period_in;
   logic                                csr_write;
   hsss_pkg::reg_index_type             csr_index;

   // input register
   logic                                in_valid_ff, in_valid_in;
   logic [NW-1:0]                       in_steps_ff, in_steps_in;
   hsss_pkg::req_kind_type              in_kind_ff, in_kind_in;

   // motor state
   logic [SW-1:0]                       pos_ff, pos_in;
   logic                                dir_ff, dir_in;
   logic [NW-1:0]                       rem_ff, rem_in;
   logic [TW-1:0]                       elapsed_ff, elapsed_in;
   logic [hsss_pkg::COIL_WIDTH-1:0]     coil_ff, coil_in;

   // result register
   logic                                out_valid_ff, out_valid_in;
   hsss_pkg::rsp_type                   out_ff, out_in;

   logic                                advance;
   logic                                take_step;
   logic [TW-1:0]                       elapsed_inc;
   logic [SW:0]                         pos_plus;
   logic [SW-1:0]                       pos_step;
   logic [NW-1:0]                       move_mag;
   logic [SW-1:0]                       spr_last;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = hsss_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      spr_in    = spr_ff;
      period_in = period_ff;
      if (csr_write) begin
         unique case (csr_index)
            hsss_pkg::REG_STEPS_PER_REV: spr_in    = csr_pwdata[SW-1:0];
            hsss_pkg::REG_STEP_PERIOD:   period_in = csr_pwdata[hsss_pkg::PERIOD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         hsss_pkg::REG_STEPS_PER_REV:
            csr_prdata = {{(hsss_pkg::CSR_DATA_WIDTH-SW){1'b0}}, spr_ff};
         hsss_pkg::REG_STEP_PERIOD:
            csr_prdata = {{(hsss_pkg::CSR_DATA_WIDTH-hsss_pkg::PERIOD_WIDTH){1'b0}}, period_ff};
         default: csr_prdata = '0;
      endcase
   end

   // handshakes
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_steps_in = in_steps_ff;
      in_kind_in  = in_kind_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_steps_in = req_tdata;
         in_kind_in  = hsss_pkg::req_kind_type'(req_tuser);
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // state update
   assign elapsed_inc = (elapsed_ff == {TW{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;
   assign take_step   = (in_kind_ff == hsss_pkg::REQ_TICK) && (rem_ff != '0)
                        && ({{(32-TW){1'b0}}, elapsed_inc}
                            >= {{(32-hsss_pkg::PERIOD_WIDTH){1'b0}}, period_ff});
   assign pos_plus    = {1'b0, pos_ff} + 1'b1;
   assign spr_last    = spr_ff - 1'b1;
   assign move_mag    = in_steps_ff[NW-1] ? NW'(-in_steps_ff) : in_steps_ff;

   always_comb begin
      if (spr_ff == '0) begin
         pos_step = '0;
      end else if (dir_ff) begin
         pos_step = (pos_plus >= {1'b0, spr_ff}) ? '0 : pos_plus[SW-1:0];
      end else begin
         pos_step = ((pos_ff == '0) || (pos_ff >= spr_ff)) ? spr_last : pos_ff - 1'b1;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      dir_in     = dir_ff;
      rem_in     = rem_ff;
      elapsed_in = elapsed_ff;
      coil_in    = coil_ff;
      if (advance) begin
         unique case (in_kind_ff)
            hsss_pkg::REQ_MOVE: begin
               if (in_steps_ff != '0) begin
                  dir_in = !in_steps_ff[NW-1];
                  rem_in = move_mag;
               end
            end
            hsss_pkg::REQ_TICK: begin
               elapsed_in = elapsed_inc;
               if (take_step) begin
                  elapsed_in = '0;
                  pos_in     = pos_step;
                  rem_in     = rem_ff - 1'b1;
                  coil_in    = hsss_pkg::half_step_coils(pos_step[hsss_pkg::PHASE_WIDTH-1:0]);
               end
            end
            default: ;
         endcase
         if (rem_in == '0) begin
            coil_in = '0;
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      if (advance) begin
         out_in.coils           = coil_in;
         out_in.position        = pos_in;
         out_in.steps_remaining = rem_in;
         out_in.busy_res        = (rem_in != '0);
         out_in.stepped         = take_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff       <= hsss_pkg::SPR_RESET;
         period_ff    <= hsss_pkg::PERIOD_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         dir_ff       <= 1'b0;
         rem_ff       <= '0;
         elapsed_ff   <= '1;
         coil_ff      <= '0;
      end else begin
         spr_ff       <= spr_in;
         period_ff    <= period_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         dir_ff       <= dir_in;
         rem_ff       <= rem_in;
         elapsed_ff   <= elapsed_in;
         coil_ff      <= coil_in;
      end
   end

   always_ff @(posedge clock) begin
      in_steps_ff <= in_steps_in;
      in_kind_ff  <= in_kind_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(hsss_pkg::RSP_DATA_WIDTH - $bits(hsss_pkg::rsp_type)){1'b0}}, out_ff};

   // coils are off whenever the move is done
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_ff.busy_res |-> out_ff.coils == '0)
      else $error("coils driven with no steps remaining");

   // a step in a running move leaves a live coil pattern
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.stepped && out_ff.busy_res |-> out_ff.coils != '0)
      else $error("step taken without a coil pattern");

   // a step restarts the timer
   assert property (@(posedge clock) disable iff (reset)
      advance && take_step |=> elapsed_ff == '0)
      else $error("timer not cleared after a step");

   // busy flag agrees with the remaining count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ff.busy_res == (out_ff.steps_remaining != '0))
      else $error("busy flag disagrees with remaining count");

   // a step always consumes one remaining step
   assert property (@(posedge clock) disable iff (reset)
      advance && take_step |=> rem_ff == $past(rem_ff) - 1'b1)
      else $error("remaining count not lowered by a step");

endmodule

`default_nettype wire

// ----- tb/tb_half_step_stepper_sequencer.sv -----
// testbench: half-step stepper sequencer checked beat by beat against a local predictor
`timescale 1ns / 1ps

module tb_half_step_stepper_sequencer;

   localparam int HOLD_CYCLES = 80;
   localparam int MAX_PRINTS = 100;
   localparam logic [hsss_pkg::TIMER_WIDTH-1:0] TIMER_FULL = {hsss_pkg::TIMER_WIDTH{1'b1}};
   // coil pattern per phase, phase 0 in the low nibble
   localparam logic [31:0] HALF_STEP_PATTERN = 32'h98C4_6231;

   typedef struct {
      hsss_pkg::req_kind_type           kind;
      logic [hsss_pkg::STEPS_WIDTH-1:0] amount;
   } motor_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [hsss_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [hsss_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [hsss_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [hsss_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [hsss_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   motor_cmd_type cmd_backlog[$];
   hsss_pkg::rsp_type results_due[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req = 0;

   // predictor copy of the registers and motor state
   logic [hsss_pkg::SPR_WIDTH-1:0]    cfg_spr = hsss_pkg::SPR_RESET;
   logic [hsss_pkg::PERIOD_WIDTH-1:0] cfg_period = hsss_pkg::PERIOD_RESET;
   logic [hsss_pkg::SPR_WIDTH-1:0]    mot_pos = '0;
   logic                              mot_fwd = 1'b0;
   logic [hsss_pkg::STEPS_WIDTH-1:0]  mot_left = '0;
   logic [hsss_pkg::TIMER_WIDTH-1:0]  mot_elapsed = TIMER_FULL;
   logic [hsss_pkg::COIL_WIDTH-1:0]   mot_coils = '0;

   half_step_stepper_sequencer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic hsss_pkg::rsp_type compute_motor_result(
         input hsss_pkg::req_kind_type kind,
         input logic [hsss_pkg::STEPS_WIDTH-1:0] amount);
      hsss_pkg::rsp_type r;
      logic took;
      took = 1'b0;
      if (kind == hsss_pkg::REQ_MOVE) begin
         if (amount != '0) begin
            mot_fwd = !amount[hsss_pkg::STEPS_WIDTH-1];
            mot_left = amount[hsss_pkg::STEPS_WIDTH-1] ? ~amount + 1'b1 : amount;
         end
      end else begin
         if (mot_elapsed != TIMER_FULL) mot_elapsed = mot_elapsed + 1'b1;
         if (mot_left != '0 && mot_elapsed >= cfg_period) begin
            mot_elapsed = '0;
            if (cfg_spr == '0) begin
               mot_pos = '0;
            end else if (mot_fwd) begin
               mot_pos = (int'(mot_pos) + 1 >= int'(cfg_spr)) ? '0 : mot_pos + 1'b1;
            end else begin
               mot_pos = (mot_pos == '0 || mot_pos >= cfg_spr) ? cfg_spr - 1'b1
                                                                : mot_pos - 1'b1;
            end
            mot_left = mot_left - 1'b1;
            mot_coils = HALF_STEP_PATTERN[{mot_pos[2:0], 2'b00} +: hsss_pkg::COIL_WIDTH];
            took = 1'b1;
         end
      end
      if (mot_left == '0) mot_coils = '0;
      r.coils = mot_coils;
      r.position = mot_pos;
      r.steps_remaining = mot_left;
      r.busy_res = (mot_left != '0);
      r.stepped = took;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got_v, input int want_v);
      if (mismatches < MAX_PRINTS)
         $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
      mismatches++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            results_due.push_back(
               compute_motor_result(hsss_pkg::req_kind_type'(req_tuser), req_tdata));
            void'(cmd_backlog.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= cmd_backlog[0].amount;
               req_tuser <= cmd_backlog[0].kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : rsp_monitor
      hsss_pkg::rsp_type want;
      hsss_pkg::rsp_type got;
      int hold_seen;
      int hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen = hold_req;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               flag_mismatch("unexpected beat",
                             int'(rsp_tdata[$bits(hsss_pkg::rsp_type)-1:0]), 0);
            end else begin
               want = results_due.pop_front();
               got = hsss_pkg::rsp_type'(rsp_tdata[$bits(hsss_pkg::rsp_type)-1:0]);
               if (got.coils != want.coils) flag_mismatch("coils", got.coils, want.coils);
               if (got.position != want.position)
                  flag_mismatch("position", got.position, want.position);
               if (got.steps_remaining != want.steps_remaining)
                  flag_mismatch("steps_remaining", got.steps_remaining, want.steps_remaining);
               if (got.busy_res != want.busy_res)
                  flag_mismatch("busy_res", got.busy_res, want.busy_res);
               if (got.stepped != want.stepped)
                  flag_mismatch("stepped", got.stepped, want.stepped);
               if (rsp_tdata[hsss_pkg::RSP_DATA_WIDTH-1:$bits(hsss_pkg::rsp_type)] != '0)
                  flag_mismatch("padding",
                     int'(rsp_tdata[hsss_pkg::RSP_DATA_WIDTH-1:$bits(hsss_pkg::rsp_type)]), 0);
            end
         end
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic queue_cmd(input hsss_pkg::req_kind_type kind,
                            input logic [hsss_pkg::STEPS_WIDTH-1:0] amount);
      motor_cmd_type c;
      c.kind = kind;
      c.amount = amount;
      cmd_backlog.push_back(c);
   endtask

   task automatic queue_tick();
      queue_cmd(hsss_pkg::REQ_TICK, hsss_pkg::STEPS_WIDTH'($urandom));
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input hsss_pkg::reg_index_type idx,
                            input logic [hsss_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == hsss_pkg::REG_STEPS_PER_REV) cfg_spr = value[hsss_pkg::SPR_WIDTH-1:0];
      else cfg_period = value[hsss_pkg::PERIOD_WIDTH-1:0];
   endtask

   task automatic add_random_items(input int count);
      int roll;
      logic [hsss_pkg::STEPS_WIDTH-1:0] mag;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         mag = hsss_pkg::STEPS_WIDTH'($urandom_range(24, 1));
         if (roll < 76) queue_tick();
         else if (roll < 88)
            queue_cmd(hsss_pkg::REQ_MOVE, $urandom_range(1) ? mag : ~mag + 1'b1);
         else if (roll < 94)
            queue_cmd(hsss_pkg::REQ_MOVE, hsss_pkg::STEPS_WIDTH'($urandom));
         else if (roll < 96) queue_cmd(hsss_pkg::REQ_MOVE, '0);
         else if (roll < 98) queue_cmd(hsss_pkg::REQ_MOVE, 16'h8000);
         else queue_cmd(hsss_pkg::REQ_MOVE, 16'h7FFF);
      end
   endtask

   task automatic random_phase(input int spr, input int period, input int count);
      wait_drained();
      csr_write(hsss_pkg::REG_STEPS_PER_REV, spr);
      csr_write(hsss_pkg::REG_STEP_PERIOD, period);
      add_random_items(count);
   endtask

   initial begin : stimulus
      send_idle_pct = 14;
      recv_idle_pct = 81;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: saturated timer steps at once, then waits out the period
      queue_tick();
      queue_cmd(hsss_pkg::REQ_MOVE, '0);
      queue_cmd(hsss_pkg::REQ_MOVE, 16'd2);
      queue_tick();
      queue_tick();

      wait_drained();
      csr_write(hsss_pkg::REG_STEPS_PER_REV, 32767);
      csr_write(hsss_pkg::REG_STEP_PERIOD, 0);
      queue_cmd(hsss_pkg::REQ_MOVE, 16'hFFFE);
      queue_tick();
      queue_tick();

      // wrap points with the position beyond the revolution
      wait_drained();
      csr_write(hsss_pkg::REG_STEPS_PER_REV, 5);
      queue_cmd(hsss_pkg::REQ_MOVE, 16'd1);
      queue_tick();
      queue_cmd(hsss_pkg::REQ_MOVE, 16'h8000);
      queue_tick();
      queue_tick();
      queue_tick();
      queue_cmd(hsss_pkg::REQ_MOVE, 16'h7FFF);
      queue_tick();
      queue_tick();
      queue_cmd(hsss_pkg::REQ_MOVE, '0);
      queue_tick();

      wait_drained();
      csr_write(hsss_pkg::REG_STEPS_PER_REV, 32767);
      queue_cmd(hsss_pkg::REQ_MOVE, 16'hFFFF);
      queue_tick();
      wait_drained();
      csr_write(hsss_pkg::REG_STEPS_PER_REV, 5);
      queue_cmd(hsss_pkg::REQ_MOVE, 16'hFFFF);
      queue_tick();

      wait_drained();
      csr_write(hsss_pkg::REG_STEPS_PER_REV, 0);
      queue_cmd(hsss_pkg::REQ_MOVE, 16'd5);
      queue_tick();
      queue_tick();

      random_phase(8, 1, 300);
      random_phase(32767, 3, 300);

      wait_drained();
      send_idle_pct = 81;
      recv_idle_pct = 14;
      random_phase(1, 0, 300);
      random_phase(0, 2, 150);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(4096, 24'hFF_FFFF, 100);
      // long receiver hold while the sender keeps offering
      random_phase(12, 0, 150);
      hold_req <= hold_req + 1;
      random_phase($urandom_range(64, 1), $urandom_range(4, 0), 250);
      random_phase($urandom_range(32767, 1), 0, 250);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
